>>> design/battery_pack_mode_controller_top_macros.svh
// ----------------------------------------------------------------------------
// Battery pack mode controller assertion macros
// Concurrent assertion shorthands used by the controller core RTL.
// ----------------------------------------------------------------------------
`ifndef BATTERY_PACK_MODE_CONTROLLER_TOP_MACROS_SVH
`define BATTERY_PACK_MODE_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTH
`define BPMC_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("bpmc assertion failed");
`define BPMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpmc assertion failed");
`else
`define BPMC_ASSERT(lbl, clk, rst_n, expr)
`define BPMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> design/bpmc_pkg.sv
// ----------------------------------------------------------------------------
// Battery pack mode controller package
// Payload types, configuration layout and command codes.
// ----------------------------------------------------------------------------
package bpmc_pkg;

    localparam int ModW     = 16;
    localparam int LimW     = 20;
    localparam int TimeW    = 32;
    localparam int CmdW     = 3;
    localparam int ModeW    = 3;
    localparam int CposW    = 2;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 32;

    localparam int NumModulesDef = 16;

    localparam logic [CfgIdxW-1:0] CfgWatchdog  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgMaxCharge = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgMaxDisch  = 2'd2;

    localparam logic [TimeW-1:0] ResetWatchdog = 32'd5000;
    localparam logic [LimW-1:0]  ResetMaxLimit = 20'd100000;

    localparam logic [CmdW-1:0] CmdNone       = 3'd0;
    localparam logic [CmdW-1:0] CmdConnChg    = 3'd1;
    localparam logic [CmdW-1:0] CmdConnDchg   = 3'd2;
    localparam logic [CmdW-1:0] CmdDisconnect = 3'd3;
    localparam logic [CmdW-1:0] CmdSetLimits  = 3'd4;
    localparam logic [CmdW-1:0] CmdPowerSave  = 3'd5;
    localparam logic [CmdW-1:0] CmdReset      = 3'd6;

    localparam logic [CposW-1:0] CposOpen   = 2'd0;
    localparam logic [CposW-1:0] CposClosed = 2'd2;

    typedef struct packed {
        logic             prot_trip;
        logic [ModW-1:0]  module_ok_mask;
        logic [TimeW-1:0] uptime;
        logic             cmd_valid;
        logic [CmdW-1:0]  mode;
        logic [TimeW-1:0] cmd_time;
        logic [LimW-1:0]  cmd_charge_limit;
        logic [LimW-1:0]  cmd_discharge_limit;
        logic [CposW-1:0] contactor_position;
        logic             contactor_fault;
        logic             reset_allowed;
    } t_in;

    typedef struct packed {
        logic [ModeW-1:0] pack_mode_out;
        logic             open_request;
        logic             close_request;
        logic             protection_reset;
        logic             ems_expired;
        logic [LimW-1:0]  charge_limit_out;
        logic [LimW-1:0]  discharge_limit_out;
    } t_out;

    typedef struct packed {
        logic [TimeW-1:0] ems_window_ms;
        logic [LimW-1:0]  max_charge_limit;
        logic [LimW-1:0]  max_discharge_limit;
    } t_cfg;

endpackage

>>> design/battery_pack_mode_controller_top.sv
// ----------------------------------------------------------------------------
// Battery pack mode controller
// Pack mode machine with EMS watchdog, contactor requests and current limits.
//
//   Channel   Direction  Handshake            Payload
//   input     in         i_valid / o_stall    i_data (bpmc_pkg::t_in)
//   result    out        o_valid / i_stall    o_data (bpmc_pkg::t_out)
//   config    in         i_cfg_we             i_cfg_addr, i_cfg_data
//
// A beat is captured in the input register at its accepting edge, and its
// result is valid once the mode logic loads the result register. One beat is
// accepted per cycle while the result is not stalled; the mode machine
// resolves a whole tick combinationally.
// Reset is synchronous and needs no clearing pass.
// A stalled result holds the core, which then stalls the input once its
// register is full.
// ----------------------------------------------------------------------------
module battery_pack_mode_controller_top #(
    parameter int NUM_MODULES = bpmc_pkg::NumModulesDef
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bpmc_pkg::CfgIdxW-1:0]    i_cfg_addr,
    input  logic [bpmc_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic                            i_valid,
    input  bpmc_pkg::t_in                   i_data,
    output logic                            o_stall,
    output logic                            o_valid,
    output bpmc_pkg::t_out                  o_data,
    input  logic                            i_stall
);

    bpmc_pkg::t_cfg r_cfg;
    logic           s1_valid;
    bpmc_pkg::t_in  s1_data;
    logic           core_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ems_window_ms       <= bpmc_pkg::ResetWatchdog;
            r_cfg.max_charge_limit    <= bpmc_pkg::ResetMaxLimit;
            r_cfg.max_discharge_limit <= bpmc_pkg::ResetMaxLimit;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                bpmc_pkg::CfgWatchdog: begin
                    r_cfg.ems_window_ms <= i_cfg_data;
                end
                bpmc_pkg::CfgMaxCharge: begin
                    r_cfg.max_charge_limit <= i_cfg_data[bpmc_pkg::LimW-1:0];
                end
                bpmc_pkg::CfgMaxDisch: begin
                    r_cfg.max_discharge_limit <= i_cfg_data[bpmc_pkg::LimW-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    bpmc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (s1_valid),
        .o_data  (s1_data),
        .i_adv   (core_adv)
    );

    bpmc_core #(
        .NUM_MODULES (NUM_MODULES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .o_adv   (core_adv),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule

>>> design/bpmc_in_reg.sv
// ----------------------------------------------------------------------------
// Battery pack mode controller input register
// Captures one input beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module bpmc_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  bpmc_pkg::t_in i_data,
    output logic          o_stall,
    output logic          o_valid,
    output bpmc_pkg::t_in o_data,
    input  logic          i_adv
);

    logic          r_valid;
    bpmc_pkg::t_in r_data;
    logic          take;

    assign o_stall = r_valid && !i_adv;
    assign take    = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_data  <= i_data;
            end else if (i_adv) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

>>> design/bpmc_core.sv
// ----------------------------------------------------------------------------
// Battery pack mode controller core
// Pack mode machine, watchdog, limits and the registered result beat.
// ----------------------------------------------------------------------------
`include "battery_pack_mode_controller_top_macros.svh"

module bpmc_core #(
    parameter int NUM_MODULES = bpmc_pkg::NumModulesDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bpmc_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    input  bpmc_pkg::t_in  i_data,
    output logic           o_adv,
    output logic           o_valid,
    output bpmc_pkg::t_out o_data,
    input  logic           i_stall
);

    localparam int NChk = (NUM_MODULES > bpmc_pkg::ModW) ? bpmc_pkg::ModW : NUM_MODULES;
    localparam logic [bpmc_pkg::ModW-1:0] NeedMask =
        bpmc_pkg::ModW'((33'd1 << NChk) - 33'd1);

    typedef enum logic [bpmc_pkg::ModeW-1:0] {
        M_OFF        = 3'd0,
        M_PSAVE      = 3'd1,
        M_FAULT      = 3'd2,
        M_READY      = 3'd3,
        M_CONNECTING = 3'd4,
        M_CONNECTED  = 3'd5,
        M_NOT_READY  = 3'd6
    } t_mode;

    t_mode                         r_mode, n_mode;
    logic [bpmc_pkg::TimeW-1:0]    r_last, n_last;
    logic [bpmc_pkg::LimW-1:0]     r_chg, n_chg;
    logic [bpmc_pkg::LimW-1:0]     r_dchg, n_dchg;
    logic                          r_tmo, n_tmo;
    logic                          n_open, n_close, n_prot;
    logic                          r_out_valid;
    bpmc_pkg::t_out                r_out;
    logic [bpmc_pkg::TimeW-1:0]    elapsed;
    logic                          fire;
    logic                          is_disc;

    assign o_adv   = !r_out_valid || !i_stall;
    assign fire    = i_valid && o_adv;
    assign elapsed = i_data.uptime - r_last;
    assign is_disc = i_data.cmd_valid && (i_data.mode == bpmc_pkg::CmdDisconnect);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_mode  = r_mode;
        n_last  = r_last;
        n_chg   = r_chg;
        n_dchg  = r_dchg;
        n_tmo   = r_tmo;
        n_open  = 1'b0;
        n_close = 1'b0;
        n_prot  = 1'b0;
        if (i_data.prot_trip && (r_mode != M_FAULT)) begin
            n_mode = M_FAULT;
            n_chg  = '0;
            n_dchg = '0;
            n_open = 1'b1;
        end else if (((r_mode == M_CONNECTED) || (r_mode == M_CONNECTING))
                     && (elapsed > i_cfg.ems_window_ms)) begin
            n_tmo  = 1'b1;
            n_mode = M_FAULT;
            n_chg  = '0;
            n_dchg = '0;
            n_open = 1'b1;
        end else begin
            unique case (r_mode)
                M_NOT_READY: begin
                    if ((i_data.module_ok_mask & NeedMask) == NeedMask) begin
                        n_mode = M_READY;
                    end
                end
                M_READY: begin
                    if (i_data.cmd_valid) begin
                        if ((i_data.mode == bpmc_pkg::CmdConnChg)
                            || (i_data.mode == bpmc_pkg::CmdConnDchg)) begin
                            n_close = 1'b1;
                            n_mode  = M_CONNECTING;
                            n_last  = i_data.uptime;
                        end else if (i_data.mode == bpmc_pkg::CmdPowerSave) begin
                            n_mode = M_PSAVE;
                        end
                    end
                end
                M_CONNECTING: begin
                    if (i_data.cmd_valid && (i_data.mode != bpmc_pkg::CmdNone)) begin
                        n_last = i_data.cmd_time;
                    end
                    if (i_data.contactor_position == bpmc_pkg::CposClosed) begin
                        n_mode = M_CONNECTED;
                    end else if (i_data.contactor_position == bpmc_pkg::CposOpen) begin
                        n_mode = M_READY;
                    end else if (i_data.contactor_fault) begin
                        n_mode = M_FAULT;
                        n_chg  = '0;
                        n_dchg = '0;
                        n_open = 1'b1;
                    end
                    if (is_disc) begin
                        n_open = 1'b1;
                        n_mode = M_READY;
                    end
                end
                M_CONNECTED: begin
                    if (i_data.cmd_valid) begin
                        n_last = i_data.cmd_time;
                        if (i_data.mode == bpmc_pkg::CmdDisconnect) begin
                            n_open = 1'b1;
                            n_mode = M_READY;
                        end else if (i_data.mode == bpmc_pkg::CmdSetLimits) begin
                            if (i_data.cmd_charge_limit < r_chg) begin
                                n_chg = i_data.cmd_charge_limit;
                            end
                            if (i_data.cmd_discharge_limit < r_dchg) begin
                                n_dchg = i_data.cmd_discharge_limit;
                            end
                        end
                    end
                    if (i_data.contactor_fault) begin
                        n_mode = M_FAULT;
                        n_chg  = '0;
                        n_dchg = '0;
                        n_open = 1'b1;
                    end
                end
                M_PSAVE: begin
                    if (i_data.cmd_valid && (i_data.mode != bpmc_pkg::CmdNone)
                        && (i_data.mode != bpmc_pkg::CmdPowerSave)) begin
                        n_mode = M_READY;
                    end
                end
                M_FAULT: begin
                    if (i_data.cmd_valid && (i_data.mode == bpmc_pkg::CmdReset)
                        && i_data.reset_allowed) begin
                        n_prot = 1'b1;
                        n_chg  = i_cfg.max_charge_limit;
                        n_dchg = i_cfg.max_discharge_limit;
                        n_tmo  = 1'b0;
                        n_mode = M_READY;
                    end
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_NOT_READY;
            r_last      <= '0;
            r_chg       <= bpmc_pkg::ResetMaxLimit;
            r_dchg      <= bpmc_pkg::ResetMaxLimit;
            r_tmo       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_mode                    <= n_mode;
                r_last                    <= n_last;
                r_chg                     <= n_chg;
                r_dchg                    <= n_dchg;
                r_tmo                     <= n_tmo;
                r_out.pack_mode_out       <= n_mode;
                r_out.open_request        <= n_open;
                r_out.close_request       <= n_close;
                r_out.protection_reset    <= n_prot;
                r_out.ems_expired         <= n_tmo;
                r_out.charge_limit_out    <= n_chg;
                r_out.discharge_limit_out <= n_dchg;
                r_out_valid               <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `BPMC_ASSERT(a_fault_limits_zero, i_clk, i_rst_n,
        (r_mode != M_FAULT) || ((r_chg == '0) && (r_dchg == '0)))
    `BPMC_ASSERT(a_timeout_enters_fault, i_clk, i_rst_n,
        !$rose(r_tmo) || (r_mode == M_FAULT))
    `BPMC_ASSERT_NEXT(a_close_from_ready, i_clk, i_rst_n,
        fire && n_close, (r_mode == M_CONNECTING) && (r_out.close_request == 1'b1))
    `BPMC_ASSERT_NEXT(a_mode_holds_idle, i_clk, i_rst_n,
        !fire, $stable(r_mode) && $stable(r_chg) && $stable(r_dchg))

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// Battery pack mode controller testbench
// Drives control ticks through the valid/stall input channel, runs its own
// model of the pack mode machine, the EMS watchdog and the current limits,
// and checks every result beat field by field. It covers directed walks
// through every mode, register extremes, four idling mixes and a long output
// hold-off.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [bpmc_pkg::ModeW-1:0] ModePowerSave  = 3'd1;
    localparam logic [bpmc_pkg::ModeW-1:0] ModeFault      = 3'd2;
    localparam logic [bpmc_pkg::ModeW-1:0] ModeReady      = 3'd3;
    localparam logic [bpmc_pkg::ModeW-1:0] ModeConnecting = 3'd4;
    localparam logic [bpmc_pkg::ModeW-1:0] ModeConnected  = 3'd5;
    localparam logic [bpmc_pkg::ModeW-1:0] ModeNotReady   = 3'd6;

    localparam logic [bpmc_pkg::CmdW-1:0]  CmdUnknown     = 3'd7;
    localparam logic [bpmc_pkg::CposW-1:0] CposPrecharge  = 2'd1;
    localparam logic [bpmc_pkg::CposW-1:0] CposOther      = 2'd3;

    localparam int QuietLimit = 5000;
    localparam int LongHold   = 300;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_cfg_we   = 1'b0;
    logic [bpmc_pkg::CfgIdxW-1:0]  i_cfg_addr = '0;
    logic [bpmc_pkg::CfgDataW-1:0] i_cfg_data = '0;
    logic                          i_valid    = 1'b0;
    bpmc_pkg::t_in                 i_data     = '0;
    logic                          o_stall;
    logic                          o_valid;
    bpmc_pkg::t_out                o_data;
    logic                          i_stall    = 1'b0;

    battery_pack_mode_controller_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall)
    );

    always #5ns i_clk = ~i_clk;

    // Model state and register copies.
    logic [bpmc_pkg::ModeW-1:0] mode_q      = ModeNotReady;
    logic [bpmc_pkg::TimeW-1:0] last_ems_ms = '0;
    logic [bpmc_pkg::LimW-1:0]  chg_lim     = bpmc_pkg::ResetMaxLimit;
    logic [bpmc_pkg::LimW-1:0]  dchg_lim    = bpmc_pkg::ResetMaxLimit;
    logic                       ems_to_flag = 1'b0;
    logic [bpmc_pkg::TimeW-1:0] wd_ms       = bpmc_pkg::ResetWatchdog;
    logic [bpmc_pkg::LimW-1:0]  max_chg     = bpmc_pkg::ResetMaxLimit;
    logic [bpmc_pkg::LimW-1:0]  max_dchg    = bpmc_pkg::ResetMaxLimit;

    logic [bpmc_pkg::TimeW-1:0] now_ms = '0;
    bpmc_pkg::t_out   status_q[$];
    int               idle_pct     = 0;
    int               stall_pct    = 0;
    int               hold_req     = 0;
    int               hold_left    = 0;
    int               quiet_cycles = 0;
    int               mismatches   = 0;
    int               ticks_sent   = 0;
    int               beats_checked = 0;

    function automatic void trip_fault();
        mode_q   = ModeFault;
        chg_lim  = '0;
        dchg_lim = '0;
    endfunction

    function automatic bpmc_pkg::t_out next_pack_status(bpmc_pkg::t_in t);
        logic [bpmc_pkg::TimeW-1:0] elapsed;
        logic             opn;
        logic             cls;
        logic             prt;
        logic             settled;
        bpmc_pkg::t_out   r;
        opn = 1'b0;
        cls = 1'b0;
        prt = 1'b0;
        settled = 1'b0;
        if (t.prot_trip && mode_q != ModeFault) begin
            trip_fault();
            opn = 1'b1;
            settled = 1'b1;
        end
        if (!settled && (mode_q == ModeConnected || mode_q == ModeConnecting)) begin
            elapsed = t.uptime - last_ems_ms;
            if (elapsed > wd_ms) begin
                ems_to_flag = 1'b1;
                trip_fault();
                opn = 1'b1;
                settled = 1'b1;
            end
        end
        if (!settled) begin
            case (mode_q)
                ModeNotReady: begin
                    if (t.module_ok_mask == 16'hFFFF) mode_q = ModeReady;
                end
                ModeReady: begin
                    if (t.cmd_valid) begin
                        if (t.mode == bpmc_pkg::CmdConnChg
                            || t.mode == bpmc_pkg::CmdConnDchg) begin
                            cls = 1'b1;
                            mode_q = ModeConnecting;
                            last_ems_ms = t.uptime;
                        end else if (t.mode == bpmc_pkg::CmdPowerSave) begin
                            mode_q = ModePowerSave;
                        end
                    end
                end
                ModeConnecting: begin
                    if (t.cmd_valid && t.mode != bpmc_pkg::CmdNone) last_ems_ms = t.cmd_time;
                    if (t.contactor_position == bpmc_pkg::CposClosed) begin
                        mode_q = ModeConnected;
                    end else if (t.contactor_position == bpmc_pkg::CposOpen) begin
                        mode_q = ModeReady;
                    end else if (t.contactor_fault) begin
                        trip_fault();
                        opn = 1'b1;
                    end
                    if (t.cmd_valid && t.mode == bpmc_pkg::CmdDisconnect) begin
                        opn = 1'b1;
                        mode_q = ModeReady;
                    end
                end
                ModeConnected: begin
                    if (t.cmd_valid) begin
                        last_ems_ms = t.cmd_time;
                        if (t.mode == bpmc_pkg::CmdDisconnect) begin
                            opn = 1'b1;
                            mode_q = ModeReady;
                        end else if (t.mode == bpmc_pkg::CmdSetLimits) begin
                            if (t.cmd_charge_limit < chg_lim) chg_lim = t.cmd_charge_limit;
                            if (t.cmd_discharge_limit < dchg_lim) begin
                                dchg_lim = t.cmd_discharge_limit;
                            end
                        end
                    end
                    if (t.contactor_fault) begin
                        trip_fault();
                        opn = 1'b1;
                    end
                end
                ModePowerSave: begin
                    if (t.cmd_valid && t.mode != bpmc_pkg::CmdNone
                        && t.mode != bpmc_pkg::CmdPowerSave) begin
                        mode_q = ModeReady;
                    end
                end
                ModeFault: begin
                    if (t.cmd_valid && t.mode == bpmc_pkg::CmdReset && t.reset_allowed) begin
                        prt = 1'b1;
                        chg_lim = max_chg;
                        dchg_lim = max_dchg;
                        ems_to_flag = 1'b0;
                        mode_q = ModeReady;
                    end
                end
                default: begin
                end
            endcase
        end
        r.pack_mode_out       = mode_q;
        r.open_request        = opn;
        r.close_request       = cls;
        r.protection_reset    = prt;
        r.ems_expired         = ems_to_flag;
        r.charge_limit_out    = chg_lim;
        r.discharge_limit_out = dchg_lim;
        return r;
    endfunction

    function automatic bpmc_pkg::t_in calm_tick(logic [bpmc_pkg::TimeW-1:0] up);
        bpmc_pkg::t_in t;
        t = '0;
        t.module_ok_mask = 16'hFFFF;
        t.uptime = up;
        t.mode = bpmc_pkg::CmdNone;
        t.cmd_time = up;
        t.contactor_position = CposPrecharge;
        return t;
    endfunction

    function automatic bpmc_pkg::t_in cmd_tick(logic [bpmc_pkg::TimeW-1:0] up,
                                               logic [bpmc_pkg::CmdW-1:0] code);
        bpmc_pkg::t_in t;
        t = calm_tick(up);
        t.cmd_valid = 1'b1;
        t.mode = code;
        return t;
    endfunction

    // Random tick whose command and contactor status lean toward what the
    // current mode needs, so that most runs get past ready into the
    // connected states and back out through faults and resets.
    function automatic bpmc_pkg::t_in random_tick();
        bpmc_pkg::t_in              t;
        int                         r;
        logic [bpmc_pkg::TimeW-1:0] cap;
        cap = (wd_ms > 2000) ? 32'd2000 : wd_ms;
        r = $urandom_range(99);
        if (r < 88) now_ms = now_ms + $urandom_range(0, cap);
        else if (r < 96) now_ms = now_ms + wd_ms + $urandom_range(1, 50);
        else now_ms = $urandom;
        t.prot_trip = ($urandom_range(99) < 3);
        t.module_ok_mask = ($urandom_range(99) < 75) ? 16'hFFFF : 16'($urandom);
        t.uptime = now_ms;
        t.cmd_valid = ($urandom_range(99) < 60);
        t.cmd_time = ($urandom_range(99) < 85) ? now_ms : $urandom;
        t.cmd_charge_limit = $urandom_range(1)
                           ? bpmc_pkg::LimW'($urandom_range(0, chg_lim))
                           : bpmc_pkg::LimW'($urandom);
        t.cmd_discharge_limit = $urandom_range(1)
                              ? bpmc_pkg::LimW'($urandom_range(0, dchg_lim))
                              : bpmc_pkg::LimW'($urandom);
        t.contactor_fault = ($urandom_range(99) < 6);
        t.reset_allowed = ($urandom_range(99) < 70);
        r = $urandom_range(99);
        if ($urandom_range(99) < 30) begin
            t.mode = bpmc_pkg::CmdW'($urandom_range(0, 7));
        end else begin
            case (mode_q)
                ModeReady:
                    t.mode = (r < 85) ? ($urandom_range(1) ? bpmc_pkg::CmdConnChg
                                                           : bpmc_pkg::CmdConnDchg)
                                      : bpmc_pkg::CmdPowerSave;
                ModeConnecting:
                    t.mode = (r < 8) ? bpmc_pkg::CmdDisconnect : (r < 50) ? CmdUnknown
                           : (r < 80) ? bpmc_pkg::CmdSetLimits : bpmc_pkg::CmdNone;
                ModeConnected:
                    t.mode = (r < 6) ? bpmc_pkg::CmdDisconnect
                           : (r < 50) ? bpmc_pkg::CmdSetLimits
                           : (r < 80) ? bpmc_pkg::CmdNone : CmdUnknown;
                ModePowerSave:
                    t.mode = (r < 50) ? bpmc_pkg::CmdPowerSave
                           : (r < 70) ? bpmc_pkg::CmdNone : CmdUnknown;
                ModeFault:
                    t.mode = (r < 70) ? bpmc_pkg::CmdReset : bpmc_pkg::CmdNone;
                default:
                    t.mode = bpmc_pkg::CmdNone;
            endcase
        end
        r = $urandom_range(99);
        if (mode_q == ModeConnecting) begin
            t.contactor_position = (r < 55) ? bpmc_pkg::CposClosed
                                 : (r < 80) ? CposPrecharge
                                 : (r < 92) ? bpmc_pkg::CposOpen : CposOther;
        end else begin
            t.contactor_position = bpmc_pkg::CposW'($urandom_range(0, 3));
        end
        return t;
    endfunction

    // Called at a rising edge; returns at the edge where the beat was taken,
    // with valid still high so that a following beat can go back to back.
    task automatic send_tick(input bpmc_pkg::t_in tick);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= tick;
        do @(posedge i_clk); while (o_stall);
        status_q.push_back(next_pack_status(tick));
        ticks_sent++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) send_tick(random_tick());
    endtask

    task automatic write_pack_cfg(input logic [bpmc_pkg::TimeW-1:0] wd,
                                  input logic [bpmc_pkg::LimW-1:0] mc,
                                  input logic [bpmc_pkg::LimW-1:0] md);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= bpmc_pkg::CfgWatchdog;
        i_cfg_data <= wd;
        @(posedge i_clk);
        i_cfg_addr <= bpmc_pkg::CfgMaxCharge;
        i_cfg_data <= bpmc_pkg::CfgDataW'(mc);
        @(posedge i_clk);
        i_cfg_addr <= bpmc_pkg::CfgMaxDisch;
        i_cfg_data <= bpmc_pkg::CfgDataW'(md);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        wd_ms    = wd;
        max_chg  = mc;
        max_dchg = md;
    endtask

    task automatic test_mode_walk();
        bpmc_pkg::t_in t;
        t = calm_tick(32'd10);
        t.module_ok_mask = 16'hFFFE;
        send_tick(t);
        t = calm_tick(32'd20);
        t.module_ok_mask = 16'h7FFF;
        send_tick(t);
        t = cmd_tick(32'd30, bpmc_pkg::CmdConnChg);
        t.module_ok_mask = 16'h0000;
        send_tick(t);
        send_tick(calm_tick(32'd40));
        send_tick(cmd_tick(32'd50, CmdUnknown));
        send_tick(cmd_tick(32'd60, bpmc_pkg::CmdPowerSave));
        send_tick(cmd_tick(32'd70, bpmc_pkg::CmdPowerSave));
        send_tick(cmd_tick(32'd80, bpmc_pkg::CmdNone));
        send_tick(cmd_tick(32'd90, CmdUnknown));
        send_tick(cmd_tick(32'd100, bpmc_pkg::CmdConnChg));
        send_tick(cmd_tick(32'd4000, CmdUnknown));
        // A disconnect while connecting wins over a contactor fault.
        t = cmd_tick(32'd9000, bpmc_pkg::CmdDisconnect);
        t.contactor_position = CposOther;
        t.contactor_fault = 1'b1;
        send_tick(t);
        send_tick(cmd_tick(32'd9100, bpmc_pkg::CmdConnDchg));
        t = calm_tick(32'd9200);
        t.contactor_position = bpmc_pkg::CposOpen;
        send_tick(t);
        t = calm_tick(32'd9300);
        t.prot_trip = 1'b1;
        send_tick(t);
        t = cmd_tick(32'd9400, bpmc_pkg::CmdReset);
        t.prot_trip = 1'b1;
        send_tick(t);
        t = cmd_tick(32'd9500, bpmc_pkg::CmdReset);
        t.reset_allowed = 1'b1;
        send_tick(t);
        send_tick(cmd_tick(32'd9600, bpmc_pkg::CmdConnChg));
        t = calm_tick(32'd9700);
        t.contactor_position = bpmc_pkg::CposClosed;
        send_tick(t);
        t = cmd_tick(32'd9800, bpmc_pkg::CmdSetLimits);
        t.cmd_charge_limit = 20'd50000;
        t.cmd_discharge_limit = 20'hFFFFF;
        send_tick(t);
        send_tick(cmd_tick(32'd14800, bpmc_pkg::CmdNone));
        // In connected a contactor fault wins over a disconnect.
        t = cmd_tick(32'd14900, bpmc_pkg::CmdDisconnect);
        t.contactor_fault = 1'b1;
        send_tick(t);
        t = cmd_tick(32'd15000, bpmc_pkg::CmdReset);
        t.reset_allowed = 1'b1;
        t.cmd_time = 32'hFFFFFFFF;
        t.cmd_charge_limit = 20'hFFFFF;
        t.cmd_discharge_limit = 20'hFFFFF;
        send_tick(t);
        // The watchdog must survive the uptime wrap and still expire after it.
        send_tick(cmd_tick(32'hFFFFF000, bpmc_pkg::CmdConnChg));
        t = calm_tick(32'h00000100);
        t.contactor_position = bpmc_pkg::CposClosed;
        send_tick(t);
        send_tick(calm_tick(32'h00000389));
        t = cmd_tick(32'h00000400, bpmc_pkg::CmdReset);
        t.reset_allowed = 1'b1;
        send_tick(t);
        now_ms = 32'h00000400;
        settle();
    endtask

    task automatic test_cfg_extremes();
        write_pack_cfg(32'd1, 20'd0, 20'd0);
        run_random(150);
        settle();
        write_pack_cfg(32'hFFFFFFFF, 20'hFFFFF, 20'hFFFFF);
        run_random(150);
        settle();
    endtask

    task automatic test_idle_mixes();
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 64 : (ph == 3) ? 16 : 0;
            stall_pct = (ph == 2) ? 64 : (ph == 3) ? 16 : 0;
            write_pack_cfg($urandom_range(1, 20000), bpmc_pkg::LimW'($urandom),
                           bpmc_pkg::LimW'($urandom));
            run_random(350);
            settle();
        end
    endtask

    task automatic test_output_holdoff();
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = LongHold;
        run_random(60);
        settle();
        run_random(40);
        settle();
    endtask

    task automatic test_reset_cfg();
        idle_pct  = 16;
        stall_pct = 16;
        write_pack_cfg(bpmc_pkg::ResetWatchdog, bpmc_pkg::ResetMaxLimit,
                       bpmc_pkg::ResetMaxLimit);
        run_random(100);
        settle();
    endtask

    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic report_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on %s at beat %0d: expected %0h, got %0h",
                         what, beats_checked, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin : check_result
        bpmc_pkg::t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result beat with nothing outstanding");
            end else begin
                want = status_q.pop_front();
                report_field("pack_mode_out", 32'(want.pack_mode_out),
                             32'(o_data.pack_mode_out));
                report_field("open_request", 32'(want.open_request),
                             32'(o_data.open_request));
                report_field("close_request", 32'(want.close_request),
                             32'(o_data.close_request));
                report_field("protection_reset", 32'(want.protection_reset),
                             32'(o_data.protection_reset));
                report_field("ems_expired", 32'(want.ems_expired),
                             32'(o_data.ems_expired));
                report_field("charge_limit_out", 32'(want.charge_limit_out),
                             32'(o_data.charge_limit_out));
                report_field("discharge_limit_out", 32'(want.discharge_limit_out),
                             32'(o_data.discharge_limit_out));
            end
            beats_checked++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QuietLimit) begin
            $display("no beat moved for %0d cycles", QuietLimit);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_mode_walk();
        test_cfg_extremes();
        test_idle_mixes();
        test_output_holdoff();
        test_reset_cfg();
        repeat (8) @(posedge i_clk);
        if (status_q.size() != 0) begin
            mismatches++;
            $display("%0d results never arrived", status_q.size());
        end
        $display("Sent %0d control ticks and checked %0d result beats across all modes,",
                 ticks_sent, beats_checked);
        $display("register extremes, four idling mixes and a long output hold-off.");
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
